FILE: rtl/afc_pkg.sv
// afc_pkg: shared types and constants of the AMQP frame classifier.
// No dependencies; used by afc_capture, afc_verdict, the top and the bench.

package afc_pkg;

	localparam logic [7:0] FRAME_METHOD    = 8'd1;
	localparam logic [7:0] FRAME_HEADER    = 8'd2;
	localparam logic [7:0] FRAME_BODY      = 8'd3;
	localparam logic [7:0] FRAME_HEARTBEAT = 8'd8;

	localparam logic [7:0]  FRAME_END       = 8'hCE;
	localparam logic [15:0] CLASS_MIN       = 16'd10;
	localparam logic [15:0] CLASS_MAX       = 16'd90;
	localparam logic [15:0] CLASS_BASIC     = 16'd60;
	localparam logic [15:0] METHOD_PUBLISH  = 16'd40;
	localparam logic [15:0] METHOD_DELIVER  = 16'd60;
	localparam logic [31:0] MIN_METHOD_SIZE = 32'd4;

	localparam int          CFG_W       = 12;
	localparam logic [11:0] PAYLOAD_RST = 12'd1024;

	// header summary taken on the final byte
	typedef struct packed {
		logic        len_ge8;
		logic        len_ge12;
		logic        len_ok;
		logic        end_ok;
		logic        magic;
		logic [7:0]  type_byte;
		logic [31:0] payload_size;
		logic [15:0] class_code;
		logic [15:0] method_code;
	} snap_t;

	typedef struct packed {
		logic protocol_header;
		logic valid_frame;
		logic method_frame;
		logic publish_frame;
		logic deliver_frame;
	} verdict_t;

	function automatic logic [7:0] magic_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h41;
			2'd1: c = 8'h4D;
			2'd2: c = 8'h51;
			default: c = 8'h50;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/afc_if.sv
// Channel interfaces of the AMQP frame classifier: byte input, verdict output,
// configuration write. Depends on nothing.

interface afc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface afc_verdict_if;
	logic valid;
	logic ready;
	logic protocol_header;
	logic valid_frame;
	logic method_frame;
	logic publish_frame;
	logic deliver_frame;
	modport source (output valid, output protocol_header, output valid_frame,
		output method_frame, output publish_frame, output deliver_frame, input ready);
	modport sink (input valid, input protocol_header, input valid_frame,
		input method_frame, input publish_frame, input deliver_frame, output ready);
endinterface

interface afc_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] max_payload;
	modport source (output valid, output max_payload, input ready);
	modport sink (input valid, input max_payload, output ready);
endinterface

FILE: rtl/amqp_frame_classifier_top.sv
// amqp_frame_classifier_top: streaming AMQP 0-9-1 frame header classifier.
// Depends on afc_pkg, afc_if.sv, afc_capture, afc_verdict.
//
// Usage:
//   bytes    - one buffer byte per word, in order from offset 0; last_byte marks
//              the final byte of the buffer.
//   verdicts - one word per buffer, five verdict flags, given after the final byte.
//   cfg      - writes max_payload (reset 1024); always ready, write only while idle.
// One byte is taken every cycle while bytes.ready is high. The final byte is
// summarized into the _s1 register, and its verdict word is registered in verdict_q
// and presented on verdicts. Bytes past MAX_BUFFER_BYTES are counted as absent.
// Reset clears all captured header fields, empties both stages and restores
// max_payload. When the receiver stalls, the verdict word holds, one more final
// summary can wait in _s1, and bytes.ready drops only while both are occupied.

module amqp_frame_classifier_top #(
	parameter int MAX_BUFFER_BYTES = 4096
) (
	input logic         clk,
	input logic         arst_n,
	afc_byte_if.sink    bytes,
	afc_verdict_if.source verdicts,
	afc_cfg_if.sink     cfg
);

	localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);

	logic                        fire;
	logic                        advance;
	logic                        valid_s1;
	afc_pkg::snap_t              snap_s1;
	afc_pkg::verdict_t           verdict_q;
	logic                        out_valid_q;
	logic [afc_pkg::CFG_W-1:0]   max_payload_q;

	assign cfg.ready   = 1'b1;
	assign bytes.ready = !valid_s1 || advance;
	assign fire        = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= afc_pkg::PAYLOAD_RST;
		end else if (cfg.valid) begin
			max_payload_q <= cfg.max_payload;
		end
	end

	afc_capture #(
		.MAX_BUFFER_BYTES(MAX_BUFFER_BYTES),
		.POS_W(POS_W)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (bytes.data_byte),
		.last_byte (bytes.last_byte),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.snap_s1   (snap_s1)
	);

	afc_verdict u_verdict (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.snap_s1     (snap_s1),
		.max_payload (max_payload_q),
		.out_ready   (verdicts.ready),
		.advance     (advance),
		.out_valid_q (out_valid_q),
		.verdict_q   (verdict_q)
	);

	assign verdicts.valid           = out_valid_q;
	assign verdicts.protocol_header = verdict_q.protocol_header;
	assign verdicts.valid_frame     = verdict_q.valid_frame;
	assign verdicts.method_frame    = verdict_q.method_frame;
	assign verdicts.publish_frame   = verdict_q.publish_frame;
	assign verdicts.deliver_frame   = verdict_q.deliver_frame;

endmodule

FILE: rtl/afc_capture.sv
// afc_capture: per-word header capture and position counter, summary register _s1.
// Depends on afc_pkg.

module afc_capture #(
	parameter int MAX_BUFFER_BYTES = 4096,
	parameter int POS_W = 13
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic                  advance,
	output logic                  valid_s1,
	output afc_pkg::snap_t        snap_s1
);

	logic [POS_W-1:0] pos_q, pos_n;
	logic             magic_q, magic_n;
	logic [7:0]       type_q, type_n;
	logic [31:0]      size_q, size_n;
	logic [15:0]      class_q, class_n;
	logic [15:0]      method_q, method_n;
	logic             end_q, end_n;
	logic             cap;
	afc_pkg::snap_t   snap_n;

	always_comb begin
		cap      = pos_q < POS_W'(MAX_BUFFER_BYTES);
		pos_n    = pos_q;
		magic_n  = magic_q;
		type_n   = type_q;
		size_n   = size_q;
		class_n  = class_q;
		method_n = method_q;
		end_n    = end_q;
		if (cap) begin
			pos_n = pos_q + POS_W'(1);
			if (pos_q < POS_W'(4) && data_byte != afc_pkg::magic_char(pos_q[1:0])) begin
				magic_n = 1'b0;
			end
			if (pos_q == POS_W'(0)) begin
				type_n = data_byte;
			end else if (pos_q >= POS_W'(3) && pos_q <= POS_W'(6)) begin
				size_n = {size_q[23:0], data_byte};
			end else if (pos_q == POS_W'(7) || pos_q == POS_W'(8)) begin
				class_n = {class_q[7:0], data_byte};
			end else if (pos_q == POS_W'(9) || pos_q == POS_W'(10)) begin
				method_n = {method_q[7:0], data_byte};
			end
			if (pos_q >= POS_W'(7) && ({1'b0, size_q} + 33'd7) == 33'(pos_q)) begin
				end_n = (data_byte == afc_pkg::FRAME_END);
			end
		end
		snap_n.len_ge8      = pos_n >= POS_W'(8);
		snap_n.len_ge12     = pos_n >= POS_W'(12);
		snap_n.len_ok       = ({1'b0, size_n} + 33'd8) <= 33'(pos_n);
		snap_n.end_ok       = end_n;
		snap_n.magic        = magic_n;
		snap_n.type_byte    = type_n;
		snap_n.payload_size = size_n;
		snap_n.class_code   = class_n;
		snap_n.method_code  = method_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			magic_q  <= 1'b1;
			type_q   <= '0;
			size_q   <= '0;
			class_q  <= '0;
			method_q <= '0;
			end_q    <= 1'b0;
		end else if (fire) begin
			if (last_byte) begin
				pos_q    <= '0;
				magic_q  <= 1'b1;
				type_q   <= '0;
				size_q   <= '0;
				class_q  <= '0;
				method_q <= '0;
				end_q    <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				magic_q  <= magic_n;
				type_q   <= type_n;
				size_q   <= size_n;
				class_q  <= class_n;
				method_q <= method_n;
				end_q    <= end_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire && last_byte) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last_byte) begin
			snap_s1 <= snap_n;
		end
	end

endmodule

FILE: rtl/afc_verdict.sv
// afc_verdict: verdict logic on the header summary and the result register.
// Depends on afc_pkg.

module afc_verdict (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        valid_s1,
	input  afc_pkg::snap_t              snap_s1,
	input  logic [afc_pkg::CFG_W-1:0]   max_payload,
	input  logic                        out_ready,
	output logic                        advance,
	output logic                        out_valid_q,
	output afc_pkg::verdict_t           verdict_q
);

	afc_pkg::verdict_t v;
	logic              fits;
	logic              mthd;
	logic              known_type;
	logic              basic;

	always_comb begin
		fits = snap_s1.payload_size <= {20'd0, max_payload} && snap_s1.len_ok && snap_s1.end_ok;
		mthd = snap_s1.len_ge12 && snap_s1.type_byte == afc_pkg::FRAME_METHOD && fits;
		known_type = snap_s1.type_byte == afc_pkg::FRAME_METHOD ||
			snap_s1.type_byte == afc_pkg::FRAME_HEADER ||
			snap_s1.type_byte == afc_pkg::FRAME_BODY ||
			snap_s1.type_byte == afc_pkg::FRAME_HEARTBEAT;
		basic = mthd && snap_s1.class_code == afc_pkg::CLASS_BASIC;
		v.protocol_header = snap_s1.len_ge8 && snap_s1.magic;
		v.valid_frame     = snap_s1.len_ge8 && fits && known_type;
		v.method_frame    = mthd && snap_s1.payload_size >= afc_pkg::MIN_METHOD_SIZE &&
			snap_s1.class_code >= afc_pkg::CLASS_MIN &&
			snap_s1.class_code <= afc_pkg::CLASS_MAX && snap_s1.method_code != 16'd0;
		v.publish_frame   = basic && snap_s1.method_code == afc_pkg::METHOD_PUBLISH;
		v.deliver_frame   = basic && snap_s1.method_code == afc_pkg::METHOD_DELIVER;
	end

	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			verdict_q <= v;
		end
	end

endmodule

FILE: rtl/afc_checker.sv
// afc_checker: port-level assertions for amqp_frame_classifier_top, with its bind.
// Depends on amqp_frame_classifier_top.

module afc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [4:0] out_flags
);

	// out_flags: protocol_header, valid_frame, method_frame, publish_frame, deliver_frame
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("verdict word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_flags))
		else $error("verdict word changed while stalled");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("byte input stalled without a stalled verdict");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_flags[1] && out_flags[0]))
		else $error("publish and deliver both set");

	a_method_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_flags[2] || out_flags[1] || out_flags[0]) |-> out_flags[3])
		else $error("method verdict without valid frame");

endmodule

bind amqp_frame_classifier_top afc_checker u_afc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (bytes.ready),
	.out_valid (verdicts.valid),
	.out_ready (verdicts.ready),
	.out_flags ({verdicts.protocol_header, verdicts.valid_frame, verdicts.method_frame,
		verdicts.publish_frame, verdicts.deliver_frame})
);

FILE: test/tb_top.sv
// tb_top: self-checking bench for amqp_frame_classifier_top. Streams byte buffers through the
// byte channel and checks each verdict word against a local frame-header predictor.
// Depends on rtl/afc_pkg.sv, rtl/afc_if.sv and the classifier RTL.
`timescale 1ns / 1ps

module tb_top;

	localparam int          MAX_BUF    = 4096;
	localparam int          HDR_LEN    = 8;
	localparam int          METHOD_LEN = 12;
	localparam logic [31:0] MAGIC      = 32'h414D5150;

	class verdict_board;
		logic [12:0]       pos;
		logic              magic_ok;
		logic [7:0]        ftype;
		logic [31:0]       psize;
		logic [15:0]       cls;
		logic [15:0]       mth;
		logic              end_ok;
		logic [11:0]       max_payload;
		afc_pkg::verdict_t verdict_q[$];
		int                errors;

		function new();
			max_payload = afc_pkg::PAYLOAD_RST;
			errors = 0;
			clear();
		endfunction

		function void clear();
			pos = '0;
			magic_ok = 1'b1;
			ftype = '0;
			psize = '0;
			cls = '0;
			mth = '0;
			end_ok = 1'b0;
		endfunction

		function void take_byte(logic [7:0] b, logic l);
			longint unsigned n, sz;
			bit fits, mthd;
			afc_pkg::verdict_t v;
			if (int'(pos) < MAX_BUF) begin
				if (pos < 13'd4 && b != MAGIC[31 - 8 * int'(pos) -: 8])
					magic_ok = 1'b0;
				if (pos == 13'd0)
					ftype = b;
				else if (pos >= 13'd3 && pos <= 13'd6)
					psize = {psize[23:0], b};
				else if (pos == 13'd7 || pos == 13'd8)
					cls = {cls[7:0], b};
				else if (pos == 13'd9 || pos == 13'd10)
					mth = {mth[7:0], b};
				if (pos >= 13'd7 && {51'd0, pos} == 64'd7 + {32'd0, psize})
					end_ok = (b == afc_pkg::FRAME_END);
				pos = pos + 13'd1;
			end
			if (!l)
				return;
			n = {51'd0, pos};
			sz = {32'd0, psize};
			fits = sz <= {52'd0, max_payload} && 64'd8 + sz <= n && end_ok;
			mthd = n >= 64'(METHOD_LEN) && ftype == afc_pkg::FRAME_METHOD && fits;
			v.protocol_header = n >= 64'(HDR_LEN) && magic_ok;
			v.valid_frame = n >= 64'(HDR_LEN) && fits && (ftype == afc_pkg::FRAME_METHOD
				|| ftype == afc_pkg::FRAME_HEADER || ftype == afc_pkg::FRAME_BODY
				|| ftype == afc_pkg::FRAME_HEARTBEAT);
			v.method_frame = mthd && sz >= {32'd0, afc_pkg::MIN_METHOD_SIZE}
				&& cls >= afc_pkg::CLASS_MIN && cls <= afc_pkg::CLASS_MAX && mth != 16'd0;
			v.publish_frame = mthd && cls == afc_pkg::CLASS_BASIC
				&& mth == afc_pkg::METHOD_PUBLISH;
			v.deliver_frame = mthd && cls == afc_pkg::CLASS_BASIC
				&& mth == afc_pkg::METHOD_DELIVER;
			verdict_q.push_back(v);
			clear();
		endfunction

		function void check_verdict(afc_pkg::verdict_t got);
			afc_pkg::verdict_t want;
			if (verdict_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected verdict word %b", $time, got);
				return;
			end
			want = verdict_q.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: verdict mismatch expected %b actual %b",
					$time, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	afc_byte_if    bytes_ch();
	afc_verdict_if verdicts_ch();
	afc_cfg_if     cfg_ch();

	amqp_frame_classifier_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_ch),
		.verdicts(verdicts_ch),
		.cfg(cfg_ch)
	);

	verdict_board sb;
	logic [7:0]   frame_q[$];
	int           src_gap_pct = 22;
	int           snk_stall_pct = 76;
	int           phase_bytes;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// verdict receiver
	initial begin
		afc_pkg::verdict_t got;
		verdicts_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (verdicts_ch.valid && verdicts_ch.ready) begin
				got = {verdicts_ch.protocol_header, verdicts_ch.valid_frame,
					verdicts_ch.method_frame, verdicts_ch.publish_frame,
					verdicts_ch.deliver_frame};
				sb.check_verdict(got);
			end
			verdicts_ch.ready <= (int'($urandom_range(99)) >= snk_stall_pct);
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic l);
		while (int'($urandom_range(99)) < src_gap_pct) begin
			bytes_ch.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_ch.valid <= 1'b1;
		bytes_ch.data_byte <= b;
		bytes_ch.last_byte <= l;
		do @(posedge clk); while (!bytes_ch.ready);
		sb.take_byte(b, l);
	endtask

	task automatic send_frame();
		int n;
		n = frame_q.size();
		for (int i = 0; i < n; i++)
			put_byte(frame_q[i], i == n - 1);
		phase_bytes += n;
	endtask

	task automatic wait_drained();
		bytes_ch.valid <= 1'b0;
		while (sb.verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_payload(input logic [11:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_payload <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		sb.max_payload = v;
	endtask

	function automatic void push_be32(input logic [31:0] v);
		for (int i = 3; i >= 0; i--)
			frame_q.push_back(v[8 * i +: 8]);
	endfunction

	function automatic void build_frame();
		logic [31:0] sz;
		logic [15:0] cls, mth;
		logic [7:0]  ftype;
		logic [7:0]  cm[4];
		int          sel, nbody, cut;
		frame_q.delete();
		sel = int'($urandom_range(99));
		if (sel < 68) begin
			case ($urandom_range(6))
				0, 1, 2: ftype = afc_pkg::FRAME_METHOD;
				3: ftype = afc_pkg::FRAME_HEADER;
				4: ftype = afc_pkg::FRAME_BODY;
				5: ftype = afc_pkg::FRAME_HEARTBEAT;
				default: ftype = 8'($urandom);
			endcase
			case ($urandom_range(19))
				0: sz = $urandom;
				1, 2: sz = 32'(sb.max_payload) + $urandom_range(0, 1);
				3, 4, 5: sz = $urandom_range(0, 3);
				default: sz = $urandom_range(4, 16);
			endcase
			case ($urandom_range(7))
				0, 1, 2: cls = afc_pkg::CLASS_BASIC;
				3: cls = 16'($urandom_range(10, 90));
				4: cls = $urandom_range(0, 1) ? 16'(afc_pkg::CLASS_MIN - 16'd1)
					: 16'(afc_pkg::CLASS_MAX + 16'd1);
				5: cls = $urandom_range(0, 1) ? afc_pkg::CLASS_MIN : afc_pkg::CLASS_MAX;
				default: cls = 16'($urandom);
			endcase
			case ($urandom_range(5))
				0, 1: mth = afc_pkg::METHOD_PUBLISH;
				2, 3: mth = afc_pkg::METHOD_DELIVER;
				4: mth = 16'd0;
				default: mth = 16'($urandom);
			endcase
			cm = '{cls[15:8], cls[7:0], mth[15:8], mth[7:0]};
			frame_q.push_back(ftype);
			frame_q.push_back(8'($urandom));
			frame_q.push_back(8'($urandom));
			push_be32(sz);
			nbody = (sz <= 32'd64) ? int'(sz) : int'($urandom_range(4, 12));
			for (int i = 0; i < nbody; i++)
				frame_q.push_back(i < 4 ? cm[i] : 8'($urandom));
			frame_q.push_back($urandom_range(9) != 0 ? afc_pkg::FRAME_END : 8'($urandom));
		end else if (sel < 80) begin
			for (int i = 0; i < 4; i++)
				frame_q.push_back(MAGIC[31 - 8 * i -: 8]);
			for (int i = 0; i < 4; i++)
				frame_q.push_back(8'($urandom));
			if ($urandom_range(4) == 0)
				frame_q[$urandom_range(3)] = 8'($urandom);
		end else begin
			nbody = int'($urandom_range(1, 20));
			for (int i = 0; i < nbody; i++)
				frame_q.push_back(8'($urandom));
		end
		case ($urandom_range(9))
			0: begin
				cut = int'($urandom_range(1, 6));
				for (int i = 0; i < cut; i++)
					frame_q.push_back(8'($urandom));
			end
			1: begin
				if (frame_q.size() > 1) begin
					cut = int'($urandom_range(1, frame_q.size() - 1));
					for (int i = 0; i < cut; i++)
						void'(frame_q.pop_back());
				end
			end
			default: ;
		endcase
	endfunction

	initial begin
		sb = new();
		arst_n <= 1'b0;
		bytes_ch.valid <= 1'b0;
		bytes_ch.data_byte <= '0;
		bytes_ch.last_byte <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.max_payload <= afc_pkg::PAYLOAD_RST;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// protocol header, publish, deliver, one-byte buffer
		frame_q = '{MAGIC[31:24], MAGIC[23:16], MAGIC[15:8], MAGIC[7:0],
			8'h00, 8'h00, 8'h09, 8'h01};
		send_frame();
		frame_q = '{afc_pkg::FRAME_METHOD, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h04,
			afc_pkg::CLASS_BASIC[15:8], afc_pkg::CLASS_BASIC[7:0],
			afc_pkg::METHOD_PUBLISH[15:8], afc_pkg::METHOD_PUBLISH[7:0],
			afc_pkg::FRAME_END};
		send_frame();
		frame_q = '{afc_pkg::FRAME_METHOD, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h04,
			afc_pkg::CLASS_BASIC[15:8], afc_pkg::CLASS_BASIC[7:0],
			afc_pkg::METHOD_DELIVER[15:8], afc_pkg::METHOD_DELIVER[7:0],
			afc_pkg::FRAME_END};
		send_frame();
		frame_q = '{afc_pkg::FRAME_METHOD};
		send_frame();

		for (int p = 0; p < 3; p++) begin
			wait_drained();
			case (p)
				0: begin
					src_gap_pct = 22;
					snk_stall_pct = 76;
					write_max_payload(12'd12);
				end
				1: begin
					src_gap_pct = 76;
					snk_stall_pct = 22;
					write_max_payload(12'd0);
				end
				default: begin
					src_gap_pct = 0;
					snk_stall_pct = 0;
					write_max_payload(12'd4095);
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < 370) begin
				if ($urandom_range(99) < 3)
					wait_drained();
				build_frame();
				send_frame();
			end
		end

		wait_drained();
		repeat (6) @(posedge clk);
		if (sb.errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
rtl/afc_pkg.sv
rtl/afc_if.sv
rtl/afc_capture.sv
rtl/afc_verdict.sv
rtl/amqp_frame_classifier_top.sv
rtl/afc_checker.sv
test/tb_top.sv
